/* src/rrw_pkg.sv */
`default_nettype none

package rrw_pkg;

	localparam int unsigned HDR_BYTES = 16;
	localparam logic [5:0] WINDOW_RESET = 6'd32;
	localparam int unsigned OFFSET_W = 8;

	typedef enum logic [1:0] {
		OP_STORE,
		OP_DUP,
		OP_RETRY
	} op_t;

	typedef struct packed {
		logic        func;
		logic [31:0] sequence_number;
		logic [15:0] packet_length;
		logic        checksum_ok;
		logic [15:0] packet_handle;
		logic [15:0] space_available;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] out_handle;
		logic [9:0]  payload_bytes;
		logic [31:0] ack_number;
		logic        end_of_file_seen;
		logic        last;
	} result_t;

	// classified packet handed from the front to the back
	typedef struct packed {
		op_t                 op;
		logic [OFFSET_W-1:0] offset;
		logic [31:0]         sequence_number;
		logic [9:0]          payload;
		logic [15:0]         handle;
		logic [15:0]         space;
		logic                eof;
	} cmd_t;

	typedef struct packed {
		logic [31:0] last_in_order;
	} stat_t;

endpackage

`default_nettype wire

/* src/receive_reorder_window_core.sv */
// Receive reorder window. Pulse start with a packet descriptor or a retry while busy is low;
// results come out on result with a one-cycle result_stb and must be taken as they appear,
// with result.last set on the final result of the item. A stored packet passes the classifier
// and the command queue, writes its slot in S_STORE, then passes S_READ and S_CHECK once per
// in-order delivery (slot store read at the ring head, then fit check) and once more for the
// final check, and ends in S_ACK for the cumulative ack. A duplicate goes straight to S_ACK;
// a retry ends after its final check. A dropped packet holds busy for a single cycle and
// gives no result.
// The slot valid bits clear at reset, so the block is ready at once.
`default_nettype none

module receive_reorder_window_core #(
	parameter int WINDOW_DEPTH = 32,
	parameter int MAX_PAYLOAD = 1000
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire rrw_pkg::item_t   packet,
	input  wire logic             cfg_we,
	input  wire logic [5:0]       cfg_wdata,
	output rrw_pkg::result_t      result,
	output logic                  result_stb
);

	logic           accept;
	logic           push;
	logic           pop;
	logic           q_empty;
	logic           front_active;
	logic           back_active;
	rrw_pkg::cmd_t  push_cmd;
	rrw_pkg::cmd_t  head_cmd;
	rrw_pkg::stat_t stat;

	assign accept = start && !busy;
	assign busy   = front_active || !q_empty || back_active;

	rrw_front #(
		.WINDOW_DEPTH(WINDOW_DEPTH),
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.packet(packet),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.stat(stat),
		.push(push),
		.cmd(push_cmd),
		.active(front_active)
	);

	rrw_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_cmd(push_cmd),
		.pop(pop),
		.rd_cmd(head_cmd),
		.empty(q_empty)
	);

	rrw_back #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_cmd(head_cmd),
		.pop(pop),
		.active(back_active),
		.stat(stat),
		.result(result),
		.result_stb(result_stb)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after a transfer");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !result_stb)
		else $error("result strobe right after a transfer");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(result_stb && result.last) |=> !result_stb)
		else $error("result follows the final result of an item");

endmodule

`default_nettype wire

/* src/rrw_front.sv */
`default_nettype none

module rrw_front #(
	parameter int WINDOW_DEPTH = 32,
	parameter int MAX_PAYLOAD = 1000
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire rrw_pkg::item_t packet,
	input  wire logic          cfg_we,
	input  wire logic [5:0]    cfg_wdata,
	input  wire rrw_pkg::stat_t stat,
	output logic               push,
	output rrw_pkg::cmd_t      cmd,
	output logic               active
);

	localparam logic [16:0] LEN_MAX   = 17'(rrw_pkg::HDR_BYTES + MAX_PAYLOAD);
	localparam logic [15:0] LEN_HDR   = 16'(rrw_pkg::HDR_BYTES);
	localparam logic [31:0] DEPTH_32  = 32'(WINDOW_DEPTH);

	logic [5:0]      window_q;
	logic            v_s1;
	rrw_pkg::item_t  item_s1;
	logic [31:0]     win;
	logic [31:0]     seq_delta;
	logic            bad;
	logic            in_win;
	logic            dup;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= rrw_pkg::WINDOW_RESET;
			v_s1     <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_wdata;
			end
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= packet;
		end
	end

	always_comb begin
		// saturate the window to one..depth
		if (window_q == 6'd0) begin
			win = 32'd1;
		end else if ({26'd0, window_q} > DEPTH_32) begin
			win = DEPTH_32;
		end else begin
			win = {26'd0, window_q};
		end
		seq_delta = item_s1.sequence_number - stat.last_in_order;
		bad    = !item_s1.checksum_ok || (item_s1.packet_length < LEN_HDR)
			|| ({1'b0, item_s1.packet_length} > LEN_MAX);
		in_win = (seq_delta != 32'd0) && (seq_delta <= win);
		dup    = (seq_delta == 32'd0) || seq_delta[31];

		cmd.offset          = rrw_pkg::OFFSET_W'(seq_delta - 32'd1);
		cmd.sequence_number = item_s1.sequence_number;
		cmd.payload         = 10'(item_s1.packet_length - LEN_HDR);
		cmd.handle          = item_s1.packet_handle;
		cmd.space           = item_s1.space_available;
		cmd.eof             = (item_s1.packet_length == LEN_HDR);
		if (item_s1.func) begin
			cmd.op = rrw_pkg::OP_RETRY;
		end else if (in_win) begin
			cmd.op = rrw_pkg::OP_STORE;
		end else begin
			cmd.op = rrw_pkg::OP_DUP;
		end
		// drop corrupt, misized and beyond-window packets here
		push = v_s1 && (item_s1.func || (!bad && (in_win || dup)));
	end

	assign active = v_s1;

endmodule

`default_nettype wire

/* src/rrw_queue.sv */
`default_nettype none

module rrw_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire rrw_pkg::cmd_t wr_cmd,
	input  wire logic          pop,
	output rrw_pkg::cmd_t      rd_cmd,
	output logic               empty
);

	rrw_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_push;
	logic          do_pop;

	assign empty   = (count_q == 2'd0);
	assign do_push = push && (count_q != 2'd2);
	assign do_pop  = pop && !empty;
	assign rd_cmd  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

`default_nettype wire

/* src/rrw_back.sv */
`default_nettype none

module rrw_back #(
	parameter int WINDOW_DEPTH = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_empty,
	input  wire rrw_pkg::cmd_t q_cmd,
	output logic               pop,
	output logic               active,
	output rrw_pkg::stat_t     stat,
	output rrw_pkg::result_t   result,
	output logic               result_stb
);

	localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam logic [SLOT_W:0]   DEPTH_V = (SLOT_W + 1)'(WINDOW_DEPTH);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_STORE,
		S_READ,
		S_CHECK,
		S_ACK
	} state_t;

	state_t            state_q;
	rrw_pkg::cmd_t     cmd_q;
	logic [15:0]       space_q;
	logic [SLOT_W-1:0] head_q;
	logic [31:0]       last_in_order_q;
	logic              eof_q;
	logic [WINDOW_DEPTH-1:0] valid_q;
	rrw_pkg::result_t  pend_q;
	logic              pend_valid_q;
	rrw_pkg::result_t  result_q;
	logic              result_stb_q;

	logic [31:0] seq_mem    [WINDOW_DEPTH];
	logic [9:0]  len_mem    [WINDOW_DEPTH];
	logic [15:0] handle_mem [WINDOW_DEPTH];
	logic [31:0] rd_seq_q;
	logic [9:0]  rd_len_q;
	logic [15:0] rd_handle_q;

	logic [SLOT_W:0]   slot_sum;
	logic [SLOT_W-1:0] slot;
	logic              fits;
	rrw_pkg::result_t  pend_out;

	always_comb begin
		slot_sum = {1'b0, head_q} + {1'b0, cmd_q.offset[SLOT_W-1:0]};
		if (slot_sum >= DEPTH_V) begin
			slot_sum = slot_sum - DEPTH_V;
		end
		slot = slot_sum[SLOT_W-1:0];
		fits = valid_q[head_q] && ({6'd0, rd_len_q} <= space_q);
		pend_out      = pend_q;
		pend_out.last = !fits && (cmd_q.op == rrw_pkg::OP_RETRY);
	end

	assign pop    = (state_q == S_IDLE) && !q_empty;
	assign active = (state_q != S_IDLE);
	assign stat.last_in_order = last_in_order_q;
	assign result     = result_q;
	assign result_stb = result_stb_q;

	// slot store: written on a stored packet, read at the ring head every cycle
	always_ff @(posedge clk) begin
		if (state_q == S_STORE) begin
			seq_mem[slot]    <= cmd_q.sequence_number;
			len_mem[slot]    <= cmd_q.payload;
			handle_mem[slot] <= cmd_q.handle;
		end
		rd_seq_q    <= seq_mem[head_q];
		rd_len_q    <= len_mem[head_q];
		rd_handle_q <= handle_mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_cmd;
		end
		if (state_q == S_CHECK && fits) begin
			pend_q.kind             <= 1'b0;
			pend_q.out_handle       <= rd_handle_q;
			pend_q.payload_bytes    <= rd_len_q;
			pend_q.ack_number       <= rd_seq_q + 32'd1;
			pend_q.end_of_file_seen <= eof_q;
			pend_q.last             <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			space_q         <= 16'd0;
			head_q          <= '0;
			last_in_order_q <= 32'd0;
			eof_q           <= 1'b0;
			valid_q         <= '0;
			pend_valid_q    <= 1'b0;
			result_q        <= '0;
			result_stb_q    <= 1'b0;
		end else begin
			result_stb_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						space_q <= q_cmd.space;
						unique case (q_cmd.op)
							rrw_pkg::OP_STORE: state_q <= S_STORE;
							rrw_pkg::OP_DUP:   state_q <= S_ACK;
							default:           state_q <= S_READ;
						endcase
					end
				end
				S_STORE: begin
					valid_q[slot] <= 1'b1;
					if (cmd_q.eof) begin
						eof_q <= 1'b1;
					end
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					// hold each delivery in pend_q until the next check so its last flag is known on transfer
					if (pend_valid_q) begin
						result_q      <= pend_out;
						result_stb_q  <= 1'b1;
					end
					if (fits) begin
						last_in_order_q <= rd_seq_q;
						valid_q[head_q] <= 1'b0;
						head_q          <= (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
						space_q         <= space_q - {6'd0, rd_len_q};
						pend_valid_q    <= 1'b1;
						state_q         <= S_READ;
					end else begin
						pend_valid_q <= 1'b0;
						state_q      <= (cmd_q.op == rrw_pkg::OP_STORE) ? S_ACK : S_IDLE;
					end
				end
				S_ACK: begin
					result_q.kind             <= 1'b1;
					result_q.out_handle       <= 16'd0;
					result_q.payload_bytes    <= 10'd0;
					result_q.ack_number       <= last_in_order_q + 32'd1;
					result_q.end_of_file_seen <= eof_q;
					result_q.last             <= 1'b1;
					result_stb_q              <= 1'b1;
					state_q                   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* tb/sv/rrw_delivery_checker.sv */
`timescale 1ns / 1ps

package rrw_codes_pkg;

	localparam logic FUNC_ARRIVAL = 1'b0;
	localparam logic FUNC_RETRY   = 1'b1;
	localparam logic KIND_DELIVER = 1'b0;
	localparam logic KIND_ACK     = 1'b1;

endpackage

module rrw_delivery_checker #(
	parameter int SLOTS = 32,
	parameter int MAX_PAYLOAD_BYTES = 1000
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             busy,
	input  wire rrw_pkg::item_t   packet,
	input  wire logic             cfg_we,
	input  wire logic [5:0]       cfg_wdata,
	input  wire rrw_pkg::result_t result,
	input  wire logic             result_stb,
	output int                    mismatches,
	output int                    results_owed
);
	import rrw_pkg::*;
	import rrw_codes_pkg::*;

	logic [5:0]  window_reg;
	logic [31:0] in_order_seq;
	logic [4:0]  head;
	logic        eof_flag;
	logic        slot_full [SLOTS];
	logic [31:0] slot_seq [SLOTS];
	logic [9:0]  slot_bytes [SLOTS];
	logic [15:0] slot_tag [SLOTS];
	result_t     owed_results[$];
	result_t     step_results[$];
	int          bad_count = 0;

	function automatic result_t make_result(input logic kind, input logic [15:0] tag,
			input logic [9:0] bytes);
		result_t r;
		r.kind = kind;
		r.out_handle = tag;
		r.payload_bytes = bytes;
		r.ack_number = in_order_seq + 32'd1;
		r.end_of_file_seen = eof_flag;
		r.last = 1'b0;
		return r;
	endfunction

	// release stored slots in order while their payload fits the downstream room
	task automatic deliver_fitting(input int unsigned room);
		int unsigned left;
		left = room;
		for (int n = 0; n < SLOTS; n++) begin
			if (!slot_full[head] || slot_bytes[head] > left)
				break;
			left -= slot_bytes[head];
			in_order_seq = slot_seq[head];
			slot_full[head] = 1'b0;
			step_results.push_back(make_result(KIND_DELIVER, slot_tag[head], slot_bytes[head]));
			head = head + 5'd1;
		end
	endtask

	task automatic absorb_item(input item_t it);
		logic [31:0] seq_delta;
		logic [4:0]  slot;
		int unsigned win;
		result_t     tail;
		step_results.delete();
		if (it.func == FUNC_RETRY) begin
			deliver_fitting(it.space_available);
		end else if (it.checksum_ok && it.packet_length >= HDR_BYTES
				&& it.packet_length <= HDR_BYTES + MAX_PAYLOAD_BYTES) begin
			if (window_reg == 6'd0)
				win = 1;
			else if (window_reg > SLOTS)
				win = SLOTS;
			else
				win = window_reg;
			seq_delta = it.sequence_number - in_order_seq;
			if (seq_delta >= 32'd1 && seq_delta <= win) begin
				slot = head + seq_delta[4:0] - 5'd1;
				slot_full[slot] = 1'b1;
				slot_seq[slot] = it.sequence_number;
				slot_bytes[slot] = 10'(it.packet_length - HDR_BYTES);
				slot_tag[slot] = it.packet_handle;
				if (it.packet_length == HDR_BYTES)
					eof_flag = 1'b1;
				deliver_fitting(it.space_available);
				step_results.push_back(make_result(KIND_ACK, 16'd0, 10'd0));
			end else if (seq_delta == 32'd0 || seq_delta[31]) begin
				// duplicate below the window: re-ack only
				step_results.push_back(make_result(KIND_ACK, 16'd0, 10'd0));
			end
		end
		if (step_results.size() > 0) begin
			tail = step_results.pop_back();
			tail.last = 1'b1;
			step_results.push_back(tail);
		end
		foreach (step_results[i])
			owed_results.push_back(step_results[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			window_reg = WINDOW_RESET;
			in_order_seq = '0;
			head = '0;
			eof_flag = 1'b0;
			foreach (slot_full[i])
				slot_full[i] = 1'b0;
			owed_results.delete();
		end else begin
			// compare before predicting: a result at this edge belongs to an older transfer
			if (result_stb) begin
				if (owed_results.size() == 0) begin
					if (bad_count < 10)
						$display("unexpected result: kind %0d handle %h bytes %0d ack %h eof %0d last %0d",
							result.kind, result.out_handle, result.payload_bytes,
							result.ack_number, result.end_of_file_seen, result.last);
					bad_count++;
				end else begin
					want = owed_results.pop_front();
					if (want.kind !== result.kind || want.out_handle !== result.out_handle
							|| want.payload_bytes !== result.payload_bytes
							|| want.ack_number !== result.ack_number
							|| want.end_of_file_seen !== result.end_of_file_seen
							|| want.last !== result.last) begin
						if (bad_count < 10)
							$display("result mismatch: expected kind %0d handle %h bytes %0d ack %h eof %0d last %0d, got kind %0d handle %h bytes %0d ack %h eof %0d last %0d",
								want.kind, want.out_handle, want.payload_bytes,
								want.ack_number, want.end_of_file_seen, want.last,
								result.kind, result.out_handle, result.payload_bytes,
								result.ack_number, result.end_of_file_seen, result.last);
						bad_count++;
					end
				end
			end
			if (cfg_we)
				window_reg = cfg_wdata;
			if (start && !busy)
				absorb_item(packet);
		end
		results_owed <= owed_results.size();
		mismatches <= bad_count;
	end

endmodule

/* tb/sv/tb_receive_reorder_window_core.sv */
`timescale 1ns / 1ps

module tb_receive_reorder_window_core;
	import rrw_pkg::*;
	import rrw_codes_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASE_ITEMS = 60;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       cfg_we = 1'b0;
	logic [5:0] cfg_wdata = '0;
	item_t      packet = '0;
	logic       busy;
	logic       result_stb;
	result_t    result;
	int         mismatches;
	int         results_owed;
	int         cycles = 0;
	int         idle_pct = 0;
	int         items_sent = 0;
	logic [31:0] base_seq;

	receive_reorder_window_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.packet     (packet),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.result     (result),
		.result_stb (result_stb)
	);

	rrw_delivery_checker window_monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.packet       (packet),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result       (result),
		.result_stb   (result_stb),
		.mismatches   (mismatches),
		.results_owed (results_owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic item_t arrival(input logic [31:0] seq, input logic [15:0] len,
			input logic ok, input logic [15:0] tag, input logic [15:0] room);
		item_t it;
		it.func = FUNC_ARRIVAL;
		it.sequence_number = seq;
		it.packet_length = len;
		it.checksum_ok = ok;
		it.packet_handle = tag;
		it.space_available = room;
		return it;
	endfunction

	// retry ignores everything but the room, so fill the rest with junk
	function automatic item_t retry(input logic [15:0] room);
		item_t it;
		it.func = FUNC_RETRY;
		it.sequence_number = $urandom;
		it.packet_length = 16'($urandom);
		it.checksum_ok = 1'($urandom);
		it.packet_handle = 16'($urandom);
		it.space_available = room;
		return it;
	endfunction

	function automatic logic [15:0] pick_room();
		int unsigned r;
		r = $urandom_range(9);
		if (r < 3)
			return 16'hFFFF;
		else if (r < 5)
			return 16'd0;
		else
			return 16'($urandom_range(0, 3000));
	endfunction

	task automatic send(input item_t it);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		packet <= it;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	// hold off until every result is in and the block has gone quiet
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (results_owed != 0 || busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input logic [5:0] value);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// up to one window's worth of packets in shuffled order, with noise, then a flush
	task automatic run_batch(input int win);
		int unsigned order [32];
		int          k;
		int          j;
		int unsigned tmp;
		logic [31:0] seq;
		logic [15:0] bad_len;
		k = ($urandom_range(3) == 0) ? win : $urandom_range(1, win);
		for (int i = 0; i < k; i++)
			order[i] = i + 1;
		for (int i = k - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < k; i++) begin
			seq = base_seq + order[i];
			if ($urandom_range(99) < 15) begin
				bad_len = $urandom_range(1) ? 16'($urandom_range(0, 15))
					: 16'($urandom_range(1017, 65535));
				if ($urandom_range(1))
					send(arrival(seq, 16'($urandom_range(17, 1016)), 1'b0,
						16'($urandom), pick_room()));
				else
					send(arrival(seq, bad_len, 1'b1, 16'($urandom), pick_room()));
			end
			send(arrival(seq, ($urandom_range(99) < 8) ? 16'd16 : 16'($urandom_range(17, 1016)),
				1'b1, 16'($urandom), pick_room()));
			if ($urandom_range(99) < 10)
				send(arrival(base_seq + order[$urandom_range(0, i)], 16'($urandom_range(16, 1016)),
					1'b1, 16'($urandom), pick_room()));
			if ($urandom_range(99) < 5)
				send(arrival(base_seq + k + win + $urandom_range(1, 40),
					16'($urandom_range(16, 1016)), 1'b1, 16'($urandom), pick_room()));
			if ($urandom_range(99) < 5) begin
				if ($urandom_range(1))
					send(retry(16'($urandom)));
				else
					send(arrival($urandom, 16'($urandom), 1'($urandom), 16'($urandom),
						16'($urandom)));
			end
		end
		if ($urandom_range(99) < 30)
			send(retry(pick_room()));
		send(retry(16'hFFFF));
		base_seq += k;
	endtask

	initial begin
		logic [5:0] windows [6];
		int         idles [6];
		int         eff;
		windows = '{6'd1, 6'd0, 6'd63, 6'd32, 6'd9, 6'd20};
		idles = '{0, 76, 10, 0, 76, 10};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: drops, duplicates, window edges, reorder, eof, slot reuse
		send(arrival(32'd1, 16'd100, 1'b0, 16'h0001, 16'hFFFF));
		send(arrival(32'd1, 16'd12, 1'b1, 16'h0002, 16'hFFFF));
		send(arrival(32'd1, 16'd15, 1'b1, 16'h0003, 16'hFFFF));
		send(arrival(32'd1, 16'd0, 1'b1, 16'h0004, 16'hFFFF));
		send(arrival(32'd1, 16'd1017, 1'b1, 16'h0005, 16'hFFFF));
		send(arrival(32'd1, 16'hFFFF, 1'b1, 16'h0006, 16'hFFFF));
		send(arrival(32'd0, 16'd100, 1'b1, 16'h0007, 16'hFFFF));
		send(arrival(32'h8000_0000, 16'd100, 1'b1, 16'h0008, 16'hFFFF));
		send(arrival(32'd33, 16'd100, 1'b1, 16'h0009, 16'hFFFF));
		send(arrival(32'h7FFF_FFFF, 16'd100, 1'b1, 16'h000A, 16'hFFFF));
		send(arrival(32'hFFFF_FFFF, 16'd50, 1'b1, 16'h000B, 16'hFFFF));
		send(arrival(32'd2, 16'd1016, 1'b1, 16'hFFFF, 16'hFFFF));
		send(arrival(32'd3, 16'd17, 1'b1, 16'h0000, 16'hFFFF));
		send(arrival(32'd32, 16'd40, 1'b1, 16'h1234, 16'hFFFF));
		send(arrival(32'd1, 16'd116, 1'b1, 16'h00C1, 16'd0));
		send(retry(16'd1100));
		send(retry(16'd0));
		send(arrival(32'd4, 16'd16, 1'b1, 16'h0E0F, 16'd1));
		send(arrival(32'd6, 16'd200, 1'b1, 16'hAAAA, 16'd0));
		send(arrival(32'd6, 16'd300, 1'b1, 16'h5555, 16'd0));
		send(arrival(32'd5, 16'd17, 1'b1, 16'h0005, 16'hFFFF));
		send(retry(16'hFFFF));
		base_seq = 32'd6;

		for (int p = 0; p < 6; p++) begin
			write_window(windows[p]);
			idle_pct = idles[p];
			if (windows[p] == 6'd0)
				eff = 1;
			else if (windows[p] > 6'd32)
				eff = 32;
			else
				eff = windows[p];
			while (items_sent < 22 + PHASE_ITEMS * (p + 1))
				run_batch(eff);
		end

		settle();
		if (mismatches == 0 && results_owed == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* files.f */
src/rrw_pkg.sv
src/rrw_front.sv
src/rrw_queue.sv
src/rrw_back.sv
src/receive_reorder_window_core.sv
tb/sv/rrw_delivery_checker.sv
tb/sv/tb_receive_reorder_window_core.sv
